// ===== design/ipcmb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipcmb_pkg
// shared constants, request and status codes of the message mailbox
// ----------------------------------------------------------------------------
package ipcmb_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int TASK_BITS_DEF    = 6;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [REQ_BITS-1:0] REQ_SEND  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_RECV  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_PURGE = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOMATCH = 2'd2;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register index, taken from byte address bit 2
    localparam logic REG_PRIV = 1'b0;

    localparam int PRIV_RESET = 1;

endpackage
`default_nettype wire

// ===== design/ipcmb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipcmb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ipcmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/ipc_message_mailbox.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipc_message_mailbox
// shared mailbox of DEPTH message slots with send, filtered receive and
// clear-by-task requests
// ----------------------------------------------------------------------------
//  channel   dir  handshake               contents
//  s_*       in   s_tvalid / s_tready     request word, kind in s_tuser
//  m_*       out  m_tvalid / m_tready     result word, status in m_tuser
//  apb       in   psel, penable, pready   privileged_task register at 0x0
//
//  messages are kept packed in insertion order in one ram, oldest at 0
//  send and unused kinds: from accept to the result state, then to the result register
//  receive: newest-first scan of the ram, then a shift-down pass over the
//  entries above the hit
//  clear: one compaction pass over the occupied entries
//  reset empties the mailbox through the fill count, no clearing pass;
//  a new word is taken once the previous result is in the output register
// ----------------------------------------------------------------------------
module ipc_message_mailbox #(
    parameter int DEPTH        = ipcmb_pkg::DEPTH_DEF,
    parameter int TASK_BITS    = ipcmb_pkg::TASK_BITS_DEF,
    parameter int PAYLOAD_BITS = ipcmb_pkg::PAYLOAD_BITS_DEF,
    localparam int IN_BITS     = 3 * TASK_BITS + 1 + PAYLOAD_BITS,
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = TASK_BITS + PAYLOAD_BITS + ipcmb_pkg::COUNT_BITS,
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // sender_id, receiver_id, any_sender, payload, purge_id
    input  wire logic [IN_W-1:0]                      s_tdata,
    // req_type
    input  wire logic [ipcmb_pkg::REQ_BITS-1:0]       s_tuser,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // msg_sender, msg_payload, removed_count
    output logic      [OUT_W-1:0]                     m_tdata,
    // status
    output logic      [ipcmb_pkg::STATUS_BITS-1:0]    m_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ipcmb_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [ipcmb_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [ipcmb_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                      pready
);

    import ipcmb_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 2 * TASK_BITS + PAYLOAD_BITS;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_PURGE, S_RESULT} state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]           data_idx_reg, data_idx_next;
    logic                    data_valid_reg, data_valid_next;
    logic [TASK_BITS-1:0]    priv_reg, priv_next;

    logic [TASK_BITS-1:0]    req_snd_reg, req_snd_next;
    logic [TASK_BITS-1:0]    req_rcv_reg, req_rcv_next;
    logic                    req_any_reg, req_any_next;
    logic [TASK_BITS-1:0]    req_pid_reg, req_pid_next;

    logic [STATUS_BITS-1:0]  res_status_reg, res_status_next;
    logic [TASK_BITS-1:0]    res_sender_reg, res_sender_next;
    logic [PAYLOAD_BITS-1:0] res_payload_reg, res_payload_next;
    logic [CNT_W-1:0]        res_count_reg, res_count_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [STATUS_BITS-1:0]  m_tuser_reg, m_tuser_next;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;

    // input word fields
    logic [TASK_BITS-1:0]    in_snd, in_rcv, in_pid;
    logic                    in_any;
    logic [PAYLOAD_BITS-1:0] in_payload;

    // fields of the entry read last cycle
    logic [TASK_BITS-1:0]    rd_snd, rd_rcv;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic                    rd_match, rd_purge, issue;

    logic [CNT_W+COUNT_BITS-1:0] count_ext;
    logic                        cfg_write;

    assign in_snd     = s_tdata[TASK_BITS-1:0];
    assign in_rcv     = s_tdata[2*TASK_BITS-1:TASK_BITS];
    assign in_any     = s_tdata[2*TASK_BITS];
    assign in_payload = s_tdata[2*TASK_BITS+PAYLOAD_BITS:2*TASK_BITS+1];
    assign in_pid     = s_tdata[3*TASK_BITS+PAYLOAD_BITS:2*TASK_BITS+PAYLOAD_BITS+1];

    assign rd_snd     = ram_rdata[TASK_BITS-1:0];
    assign rd_rcv     = ram_rdata[2*TASK_BITS-1:TASK_BITS];
    assign rd_payload = ram_rdata[ENTRY_W-1:2*TASK_BITS];

    // privileged sender passes the sender filter; the receiver must still match
    assign rd_match = (rd_rcv == req_rcv_reg)
                   && (req_any_reg || (rd_snd == req_snd_reg) || (rd_snd == priv_reg));
    assign rd_purge = (rd_snd == req_pid_reg) || (rd_rcv == req_pid_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_PRIV);
    assign prdata    = (paddr[2] == REG_PRIV) ? APB_DATA_BITS'(priv_reg) : '0;
    assign priv_next = cfg_write ? pwdata[TASK_BITS-1:0] : priv_reg;

    assign count_ext = {{COUNT_BITS{1'b0}}, res_count_reg};

    ipcmb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        issue_idx_next   = issue_idx_reg;
        wr_ptr_next      = wr_ptr_reg;
        data_idx_next    = data_idx_reg;
        data_valid_next  = data_valid_reg;
        req_snd_next     = req_snd_reg;
        req_rcv_next     = req_rcv_reg;
        req_any_next     = req_any_reg;
        req_pid_next     = req_pid_reg;
        res_status_next  = res_status_reg;
        res_sender_next  = res_sender_reg;
        res_payload_next = res_payload_reg;
        res_count_next   = res_count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = ram_rdata;
        ram_raddr        = issue_idx_reg[AW-1:0];
        issue            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_snd_next     = in_snd;
                    req_rcv_next     = in_rcv;
                    req_any_next     = in_any;
                    req_pid_next     = in_pid;
                    res_status_next  = ST_OK;
                    res_sender_next  = '0;
                    res_payload_next = '0;
                    res_count_next   = '0;
                    data_valid_next  = 1'b0;
                    case (s_tuser)
                        REQ_SEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = {in_payload, in_rcv, in_snd};
                                count_next = count_reg + 1'b1;
                            end
                            state_next = S_RESULT;
                        end
                        REQ_RECV:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOMATCH;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                issue_idx_next = count_reg - 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        REQ_PURGE:
                        begin
                            issue_idx_next = '0;
                            wr_ptr_next    = '0;
                            state_next     = S_PURGE;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (data_valid_reg && rd_match)
                begin
                    res_sender_next  = rd_snd;
                    res_payload_next = rd_payload;
                    issue_idx_next   = CNT_W'(data_idx_reg) + 1'b1;
                    data_valid_next  = 1'b0;
                    state_next       = S_SHIFT;
                end
                else if (data_valid_reg && (data_idx_reg == '0))
                begin
                    res_status_next = ST_NOMATCH;
                    data_valid_next = 1'b0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    // index wraps past zero to a value above the depth
                    issue           = (issue_idx_reg < CNT_W'(DEPTH));
                    ram_re          = issue;
                    data_valid_next = issue;
                    data_idx_next   = issue_idx_reg[AW-1:0];
                    if (issue)
                    begin
                        issue_idx_next = issue_idx_reg - 1'b1;
                    end
                end
            end
            S_SHIFT:
            begin
                // move every entry above the hit down by one
                if (data_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = data_idx_reg - 1'b1;
                end
                issue           = (issue_idx_reg < count_reg);
                ram_re          = issue;
                data_valid_next = issue;
                data_idx_next   = issue_idx_reg[AW-1:0];
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else if (!data_valid_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_PURGE:
            begin
                // survivors are packed down to the write pointer
                if (data_valid_reg && !rd_purge)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg[AW-1:0];
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                issue           = (issue_idx_reg < count_reg);
                ram_re          = issue;
                data_valid_next = issue;
                data_idx_next   = issue_idx_reg[AW-1:0];
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else if (!data_valid_reg)
                begin
                    count_next     = wr_ptr_reg;
                    res_count_next = count_reg - wr_ptr_reg;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[OUT_BITS-1:0] = {count_ext[COUNT_BITS-1:0],
                                                  res_payload_reg, res_sender_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            data_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            priv_reg       <= TASK_BITS'(PRIV_RESET);
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            data_valid_reg <= data_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            priv_reg       <= priv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg   <= issue_idx_next;
        wr_ptr_reg      <= wr_ptr_next;
        data_idx_reg    <= data_idx_next;
        req_snd_reg     <= req_snd_next;
        req_rcv_reg     <= req_rcv_next;
        req_any_reg     <= req_any_next;
        req_pid_reg     <= req_pid_next;
        res_status_reg  <= res_status_next;
        res_sender_reg  <= res_sender_next;
        res_payload_reg <= res_payload_next;
        res_count_reg   <= res_count_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write hit the same entry");

    a_result_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result word raised outside the result state");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && data_valid_reg) |-> (CNT_W'(data_idx_reg) < count_reg))
        else $error("scan read beyond the occupied entries");

    a_shift_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && state_next == S_RESULT)
        |=> (count_reg + 1'b1 == $past(count_reg)))
        else $error("receive did not remove exactly one entry");

endmodule
`default_nettype wire

// ===== test/tb_ipc_message_mailbox.sv =====
// ----------------------------------------------------------------------------
// tb_ipc_message_mailbox
// Drives send, receive and clear requests into the message mailbox and
// checks every result word against an in-bench model of the slot store.
// Covers the receive filter with the privileged task, a full mailbox,
// output stalls and random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_ipc_message_mailbox;

    import ipcmb_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int TASK_W   = TASK_BITS_DEF;
    localparam int BODY_W   = PAYLOAD_BITS_DEF;
    localparam int IN_USED  = 3 * TASK_W + 1 + BODY_W;
    localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
    localparam int OUT_USED = TASK_W + BODY_W + COUNT_BITS;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_PRIV = {REG_PRIV, 2'b00};
    // request kind the block ignores
    localparam logic [REQ_BITS-1:0] REQ_SPARE = 2'd3;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 110;

    typedef struct packed {
        logic [REQ_BITS-1:0] kind;
        logic [TASK_W-1:0]   sender;
        logic [TASK_W-1:0]   receiver;
        logic                any;
        logic [BODY_W-1:0]   body;
        logic [TASK_W-1:0]   purge;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TASK_W-1:0]      sender;
        logic [BODY_W-1:0]      body;
        logic [COUNT_BITS-1:0]  count;
    } outcome_t;

    typedef struct packed {
        logic [TASK_W-1:0] sender;
        logic [TASK_W-1:0] receiver;
        logic [BODY_W-1:0] body;
    } message_t;

    logic clk;
    logic rst_n = 1'b0;

    logic [IN_W-1:0]     s_tdata  = '0;
    logic [REQ_BITS-1:0] s_tuser  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;

    logic [OUT_W-1:0]       m_tdata;
    logic [STATUS_BITS-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // model state: held messages oldest first, newest at the back
    message_t          held_msgs[$];
    logic [TASK_W-1:0] priv_task = TASK_W'(PRIV_RESET);
    outcome_t          outcomes_due[$];
    logic [TASK_W-1:0] id_pool[4];

    int fail_count   = 0;
    bit no_idle      = 1'b0;
    bit hold_results = 1'b0;

    ipc_message_mailbox dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // applies one request to the model and returns the result word it gives
    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        message_t m;
        int       hit;
        int       removed;
        o       = '0;
        hit     = -1;
        removed = 0;
        case (r.kind)
            REQ_SEND:
            begin
                if (held_msgs.size() >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    m.sender   = r.sender;
                    m.receiver = r.receiver;
                    m.body     = r.body;
                    held_msgs.push_back(m);
                end
            end
            REQ_RECV:
            begin
                // newest first; the privileged task passes any sender filter
                for (int i = held_msgs.size() - 1; i >= 0 && hit < 0; i--)
                    if (held_msgs[i].receiver == r.receiver &&
                        (r.any || held_msgs[i].sender == r.sender ||
                         held_msgs[i].sender == priv_task))
                        hit = i;
                if (hit < 0)
                    o.status = ST_NOMATCH;
                else
                begin
                    o.sender = held_msgs[hit].sender;
                    o.body   = held_msgs[hit].body;
                    held_msgs.delete(hit);
                end
            end
            REQ_PURGE:
            begin
                for (int i = held_msgs.size() - 1; i >= 0; i--)
                    if (held_msgs[i].sender == r.purge || held_msgs[i].receiver == r.purge)
                    begin
                        held_msgs.delete(i);
                        removed++;
                    end
                o.count = COUNT_BITS'(removed);
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic request_t make_req(logic [REQ_BITS-1:0] kind, int snd, int rcv,
                                          bit any, logic [BODY_W-1:0] body, int pid);
        request_t r;
        r.kind     = kind;
        r.sender   = TASK_W'(snd);
        r.receiver = TASK_W'(rcv);
        r.any      = any;
        r.body     = body;
        r.purge    = TASK_W'(pid);
        return r;
    endfunction

    function automatic logic [TASK_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, 3)];
        return TASK_W'($urandom_range(0, (1 << TASK_W) - 1));
    endfunction

    // mostly addressed traffic among a few tasks, some noise and spare kinds
    function automatic request_t random_request();
        request_t r;
        message_t m;
        int       roll;
        roll       = $urandom_range(0, 99);
        r.sender   = pick_id();
        r.receiver = pick_id();
        r.any      = ($urandom_range(0, 3) == 0);
        r.body     = $urandom;
        r.purge    = pick_id();
        if (roll < 45)
            r.kind = REQ_SEND;
        else if (roll < 82)
            r.kind = REQ_RECV;
        else if (roll < 94)
            r.kind = REQ_PURGE;
        else
            r.kind = REQ_SPARE;
        if (held_msgs.size() > 0 && $urandom_range(0, 9) < 6)
        begin
            m = held_msgs[$urandom_range(0, held_msgs.size() - 1)];
            if (r.kind == REQ_RECV)
            begin
                r.receiver = m.receiver;
                if ($urandom_range(0, 1) == 1)
                    r.sender = m.sender;
            end
            else if (r.kind == REQ_PURGE)
                r.purge = $urandom_range(0, 1) ? m.sender : m.receiver;
        end
        return r;
    endfunction

    task automatic send_request(request_t r, bit no_gap);
        int gap;
        gap = (no_gap || no_idle) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {{(IN_W - IN_USED){1'b0}}, r.purge, r.body, r.any, r.receiver, r.sender};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        outcomes_due.push_back(apply_request(r));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_priv_reg(logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PRIV;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        priv_task = value[TASK_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(make_req(REQ_RECV, 0, 5, 1, '0, 0), 0);
        send_request(make_req(REQ_PURGE, 0, 0, 0, '0, 63), 0);
        send_request(make_req(REQ_SEND, 0, 63, 0, '0, 0), 0);
        send_request(make_req(REQ_SEND, 63, 0, 0, '1, 63), 0);
        send_request(make_req(REQ_SEND, 2, 7, 0, 32'ha5a5_a5a5, 0), 0);
        send_request(make_req(REQ_SEND, 3, 7, 0, 32'h5a5a_5a5a, 0), 0);
        send_request(make_req(REQ_SEND, 1, 7, 0, 32'h1234_5678, 0), 0);
        // privileged sender is newest and passes the filter for task 2
        send_request(make_req(REQ_RECV, 2, 7, 0, '0, 0), 0);
        send_request(make_req(REQ_RECV, 3, 7, 0, '0, 0), 0);
        send_request(make_req(REQ_RECV, 9, 7, 0, '0, 0), 0);
        send_request(make_req(REQ_RECV, 9, 7, 1, '0, 0), 0);
        send_request(make_req(REQ_RECV, 0, 63, 0, '0, 0), 0);
        send_request(make_req(REQ_SPARE, 63, 63, 1, '1, 63), 0);
        send_request(make_req(REQ_SEND, 5, 6, 0, 32'h0000_0001, 0), 0);
        send_request(make_req(REQ_SEND, 6, 5, 0, 32'h8000_0000, 0), 0);
        send_request(make_req(REQ_SEND, 8, 8, 0, 32'hdead_beef, 0), 0);
        send_request(make_req(REQ_PURGE, 0, 0, 0, '0, 5), 0);
        send_request(make_req(REQ_PURGE, 0, 0, 0, '0, 8), 0);
        send_request(make_req(REQ_RECV, 63, 0, 0, '0, 0), 0);
        send_request(make_req(REQ_PURGE, 63, 63, 1, '1, 0), 0);
        wait_idle();
    endtask

    task automatic test_full_mailbox();
        while (held_msgs.size() > 0)
            send_request(make_req(REQ_PURGE, 0, 0, 0, '0, held_msgs[0].sender), 0);
        repeat (DEPTH)
            send_request(make_req(REQ_SEND, 4, $urandom_range(10, 20), 0, $urandom, 0), 0);
        send_request(make_req(REQ_SEND, 4, 11, 0, $urandom, 0), 0);
        send_request(make_req(REQ_RECV, 0, held_msgs[0].receiver, 1, '0, 0), 0);
        send_request(make_req(REQ_SEND, 4, 12, 0, $urandom, 0), 0);
        // every slot holds a word from task 4
        send_request(make_req(REQ_PURGE, 0, 0, 0, '0, 4), 0);
        wait_idle();
    endtask

    task automatic test_result_backpressure();
        for (int k = 0; k < 4; k++)
            id_pool[k] = TASK_W'($urandom_range(0, 63));
        hold_results = 1'b1;
        repeat (30)
            send_request(random_request(), 1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [APB_DATA_BITS-1:0] reg_value;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       reg_value = 32'h0000_003f;
                1:       reg_value = 32'h0000_0000;
                2:       reg_value = 32'hffff_ffc0;
                3:       reg_value = 32'(PRIV_RESET);
                default: reg_value = $urandom;
            endcase
            write_priv_reg(reg_value);
            for (int k = 0; k < 4; k++)
                id_pool[k] = TASK_W'($urandom_range(0, 63));
            if ($urandom_range(0, 1) == 1)
                id_pool[0] = priv_task;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_request(random_request(), 0);
            end
            no_idle = 1'b0;
            wait_idle();
        end
    endtask

    // result side: random ready gaps, one long hold when asked
    initial
    begin : result_sink
        int gap;
        forever
        begin
            if (hold_results)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("field status exp %0d got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[TASK_W-1:0] !== want.sender)
                begin
                    $error("field msg_sender exp %0d got %0d", want.sender,
                           m_tdata[TASK_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[TASK_W +: BODY_W] !== want.body)
                begin
                    $error("field msg_payload exp %h got %h", want.body,
                           m_tdata[TASK_W +: BODY_W]);
                    fail_count++;
                end
                if (m_tdata[TASK_W + BODY_W +: COUNT_BITS] !== want.count)
                begin
                    $error("field removed_count exp %0d got %0d", want.count,
                           m_tdata[TASK_W + BODY_W +: COUNT_BITS]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_mailbox();
        test_result_backpressure();
        test_random_traffic();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (outcomes_due.size() != 0)
        begin
            $error("%0d result words never arrived", outcomes_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ipcmb_pkg.sv
design/ipcmb_ram.sv
design/ipc_message_mailbox.sv
test/tb_ipc_message_mailbox.sv
